/* rtl/satlb_pkg.sv */
// ----------------------------------------------------------------------------
// satlb_pkg
// Sizes, types and the update record shared by the set-associative TLB.
// ----------------------------------------------------------------------------
package satlb_pkg;

	localparam int SETS             = 16;  // power of two
	localparam int WAYS             = 4;   // power of two, at least two
	localparam int PAGE_OFFSET_BITS = 21;
	localparam int ADDR_BITS        = 64;

	// Port widths fixed by the interface
	localparam int ADDR_W      = 64;
	localparam int WAY_W       = 2;
	localparam int SET_INDEX_W = 4;

	localparam int SET_BITS  = $clog2(SETS);
	localparam int WAY_BITS  = $clog2(WAYS);
	localparam int RANK_BITS = WAY_BITS;
	localparam int TAG_BITS  = ADDR_BITS - PAGE_OFFSET_BITS - SET_BITS;
	localparam int RANK_MAX  = WAYS - 1;

	typedef logic [SET_BITS-1:0]  set_t;
	typedef logic [WAY_BITS-1:0]  way_t;
	typedef logic [RANK_BITS-1:0] rank_t;
	typedef logic [TAG_BITS-1:0]  tag_t;

	typedef logic [WAYS-1:0]                valid_row_t;
	typedef logic [WAYS-1:0][RANK_BITS-1:0] rank_row_t;
	typedef logic [WAYS-1:0][TAG_BITS-1:0]  tag_row_t;

	// Outcome of one lookup and the new state of its set
	typedef struct packed {
		logic       hit;
		way_t       way;
		logic       replaced;
		logic       wr_tag;
		valid_row_t valid;
		rank_row_t  rank;
		logic       full;
	} satlb_upd_t;

endpackage

/* rtl/satlb_ram.sv */
// ----------------------------------------------------------------------------
// satlb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module satlb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read-first on a same-address collision
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/satlb_lookup.sv */
// ----------------------------------------------------------------------------
// satlb_lookup
// Tag compare, fill/victim choice and LRU rank update for one set.
// ----------------------------------------------------------------------------
module satlb_lookup (
	input  satlb_pkg::tag_t       tag,
	input  satlb_pkg::tag_row_t   tags,
	input  satlb_pkg::valid_row_t valid,
	input  satlb_pkg::rank_row_t  rank,
	input  logic                  full,
	output satlb_pkg::satlb_upd_t upd
);
	import satlb_pkg::*;

	logic       found;
	logic       hit_f;
	way_t       sel;
	way_t       vic;
	rank_t      best;
	rank_t      hit_rank;
	rank_row_t  new_rank;
	valid_row_t new_valid;

	always_comb begin
		// ways in order: a valid match hits, else a free way in a set with room fills
		found = 1'b0;
		hit_f = 1'b0;
		sel   = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (!found) begin
				if (valid[w] && tags[w] == tag) begin
					found = 1'b1;
					hit_f = 1'b1;
					sel   = way_t'(w);
				end else if (!full && !valid[w]) begin
					found = 1'b1;
					sel   = way_t'(w);
				end
			end
		end

		// oldest rank, lowest way on a tie
		vic  = '0;
		best = rank[0];
		for (int w = 1; w < WAYS; w++) begin
			if (rank[w] > best) begin
				best = rank[w];
				vic  = way_t'(w);
			end
		end
		if (!found) begin
			sel = vic;
		end

		hit_rank  = rank[sel];
		new_rank  = rank;
		new_valid = valid;
		if (hit_f) begin
			for (int o = 0; o < WAYS; o++) begin
				if (valid[o] && rank[o] < hit_rank) begin
					new_rank[o] = rank[o] + rank_t'(1);
				end
			end
		end else begin
			for (int o = 0; o < WAYS; o++) begin
				if (way_t'(o) != sel && valid[o] && rank[o] < rank_t'(RANK_MAX)) begin
					new_rank[o] = rank[o] + rank_t'(1);
				end
			end
			new_valid[sel] = 1'b1;
		end
		new_rank[sel] = '0;

		upd.hit      = hit_f;
		upd.way      = sel;
		upd.replaced = !found;
		upd.wr_tag   = !hit_f;
		upd.valid    = new_valid;
		upd.rank     = new_rank;
		upd.full     = full || !found || (!hit_f && sel == way_t'(WAYS - 1));
	end

endmodule

/* rtl/set_assoc_tlb_lru_lookup.sv */
// ----------------------------------------------------------------------------
// set_assoc_tlb_lru_lookup
// Set-associative TLB tag lookup with LRU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Drive logical_address and raise start; the beat is taken at a clock edge
//   with start high and busy low. busy stays low, so a new address can be
//   taken on every cycle.
//   Each beat gives one result: done is high for one cycle with hit, way,
//   set_index and replaced valid in that cycle. There is no back-pressure on
//   the result side; the receiver must take it then.
//   Throughput is one address per cycle. The per-way tag RAMs are read at the
//   accepting edge, compare and LRU update follow in the next cycle, and the
//   outcome is registered onto done and the result ports; a tag written in
//   that cycle is forwarded to the following beat of the same set.
//   Reset (arst_n low) clears all valid bits, LRU ranks and set-full flags at
//   once and drops any beat in flight; tag RAM contents are not cleared and
//   are only read behind a valid bit.
// ----------------------------------------------------------------------------
module set_assoc_tlb_lru_lookup (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [satlb_pkg::ADDR_W-1:0]      logical_address,
	output logic                              done,
	output logic                              hit,
	output logic [satlb_pkg::WAY_W-1:0]       way,
	output logic [satlb_pkg::SET_INDEX_W-1:0] set_index,
	output logic                              replaced
);
	import satlb_pkg::*;

	logic       accept;
	set_t       in_set;
	tag_t       in_tag;

	logic       v_s1;
	set_t       set_s1;
	tag_t       tag_s1;

	valid_row_t valid_q [SETS];
	rank_row_t  rank_q  [SETS];
	logic       full_q  [SETS];

	logic       fwd_v_q;
	set_t       fwd_set_q;
	way_t       fwd_way_q;
	tag_t       fwd_tag_q;

	tag_row_t   ram_tags;
	tag_row_t   tags_s1;
	satlb_upd_t upd;
	logic       tag_we;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign in_set = logical_address[PAGE_OFFSET_BITS +: SET_BITS];
	assign in_tag = logical_address[ADDR_BITS-1:PAGE_OFFSET_BITS+SET_BITS];
	assign tag_we = v_s1 && upd.wr_tag;

	for (genvar w = 0; w < WAYS; w++) begin : g_way
		satlb_ram #(
			.WIDTH (TAG_BITS),
			.DEPTH (SETS)
		) u_tag_ram (
			.clk   (clk),
			.we    (tag_we && upd.way == way_t'(w)),
			.waddr (set_s1),
			.wdata (tag_s1),
			.re    (accept),
			.raddr (in_set),
			.rdata (ram_tags[w])
		);

		// the RAM read in the same edge as the write missed it
		assign tags_s1[w] = (fwd_v_q && fwd_set_q == set_s1 && fwd_way_q == way_t'(w))
			? fwd_tag_q : ram_tags[w];
	end

	satlb_lookup u_lookup (
		.tag   (tag_s1),
		.tags  (tags_s1),
		.valid (valid_q[set_s1]),
		.rank  (rank_q[set_s1]),
		.full  (full_q[set_s1]),
		.upd   (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			done    <= 1'b0;
			fwd_v_q <= 1'b0;
			for (int s = 0; s < SETS; s++) begin
				valid_q[s] <= '0;
				rank_q[s]  <= '0;
				full_q[s]  <= 1'b0;
			end
		end else begin
			v_s1    <= accept;
			done    <= v_s1;
			fwd_v_q <= tag_we;
			if (v_s1) begin
				valid_q[set_s1] <= upd.valid;
				rank_q[set_s1]  <= upd.rank;
				full_q[set_s1]  <= upd.full;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1 <= in_set;
			tag_s1 <= in_tag;
		end
		if (tag_we) begin
			fwd_set_q <= set_s1;
			fwd_way_q <= upd.way;
			fwd_tag_q <= tag_s1;
		end
		if (v_s1) begin
			hit       <= upd.hit;
			way       <= WAY_W'(upd.way);
			set_index <= SET_INDEX_W'(set_s1);
			replaced  <= upd.replaced;
		end
	end

endmodule

/* rtl/satlb_checker.sv */
// ----------------------------------------------------------------------------
// satlb_checker
// Port-level checks on the TLB lookup, bound to the top level.
// ----------------------------------------------------------------------------
module satlb_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic [satlb_pkg::ADDR_W-1:0]      logical_address,
	input logic                              done,
	input logic                              hit,
	input logic [satlb_pkg::WAY_W-1:0]       way,
	input logic [satlb_pkg::SET_INDEX_W-1:0] set_index,
	input logic                              replaced
);

	// every accepted beat later gives its result on done
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted beat produced no result");

	// no result without an earlier accepted beat
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && arst_n, 2))
		else $error("result without an accepted beat");

	// eviction only happens on a miss
	a_replace_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(hit && replaced))
		else $error("hit reported together with replacement");

	// same address twice back to back must hit the second time (tag forwarding)
	a_repeat_hits: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) ##1 (start && !busy && logical_address == $past(logical_address))
		|-> ##2 (done && hit))
		else $error("back-to-back repeat address missed");

endmodule

bind set_assoc_tlb_lru_lookup satlb_checker u_satlb_checker (.*);
